### src/humidity_sensor_frame_decoder_macros.svh
// Assertion macros shared by the decoder modules.
// Each module that uses them has clk and rst in scope.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_MACROS_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HSFD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsfd assertion failed");

// Next-cycle implication, disabled during reset
`define HSFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsfd assertion failed");

`endif

### src/hsfd_pkg.sv
package hsfd_pkg;

  // CRC-8 as used by the sensor: poly 0x31, init 0xFF, MSB first
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Conversion constants (fixed point, result taken >> 16)
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] HUM_SCALE   = 15'd100;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Operation codes passed from front to back
  localparam logic [1:0] OP_TRAW = 2'd0;  // temperature word complete
  localparam logic [1:0] OP_TCHK = 2'd1;  // temperature CRC byte checked
  localparam logic [1:0] OP_HRAW = 2'd2;  // humidity word complete
  localparam logic [1:0] OP_HCHK = 2'd3;  // humidity CRC byte checked, frame done

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] raw;
    logic        ok;
  } hsfd_op_t;

  // One byte of the CRC-8 update
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### src/hsfd_if.sv
// Byte channel into the decoder
interface hsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// Reading channel out of the decoder
interface hsfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic [6:0]         humidity_percent;
  logic               temperature_fresh;
  logic               humidity_fresh;

  modport source (output valid, output temperature_centi, output humidity_percent,
                  output temperature_fresh, output humidity_fresh, input ready);
  modport sink   (input valid, input temperature_centi, input humidity_percent,
                  input temperature_fresh, input humidity_fresh, output ready);
endinterface

### src/humidity_sensor_frame_decoder.sv
// Channel   Dir  Word
// frame     in   data_byte[7:0], frame_start
// reading   out  temperature_centi[14:0] signed, humidity_percent[6:0],
//                temperature_fresh, humidity_fresh
//
// One byte accepted per cycle while the queue has room; a frame's reading
// passes the queue, multiply and update registers after its sixth byte is taken.
// The back-end multiplier sets the pace: one queued op per cycle unless stalled.
// Reset (rst, synchronous) sets CRC to 0xFF; position, queue, held readings to 0.
// A stalled reading holds the back end; the queue then fills and frame.ready
// drops once it is full.
module humidity_sensor_frame_decoder
  import hsfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  hsfd_in_if.sink   frame,
  hsfd_out_if.source reading
);

  logic     push_valid, push_ready;
  hsfd_op_t push_op;
  logic     pop_valid, pop_ready;
  hsfd_op_t pop_op;

  hsfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  hsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  hsfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .reading   (reading)
  );

endmodule

### src/hsfd_front.sv
`include "humidity_sensor_frame_decoder_macros.svh"

module hsfd_front
  import hsfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  hsfd_in_if.sink  frame,
  output logic     push_valid,
  input  logic     push_ready,
  output hsfd_op_t push_op
);

  // Byte positions within the frame
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  logic [2:0] position, position_next;
  logic [7:0] running_crc, running_crc_next;
  logic [7:0] high_byte, high_byte_next;
  logic [2:0] pos_eff;
  logic       has_op;
  logic       accept;

  // Start mark or a stray position restarts the frame
  assign pos_eff = (frame.frame_start || position > POS_H_CRC) ? POS_T_HI : position;

  // Classify the byte and work out the next front state
  always_comb begin
    position_next    = position;
    running_crc_next = running_crc;
    high_byte_next   = high_byte;
    has_op           = 1'b0;
    push_op.kind     = OP_TRAW;
    push_op.raw      = {high_byte, frame.data_byte};
    push_op.ok       = (running_crc == frame.data_byte);
    unique case (pos_eff)
      POS_T_HI, POS_H_HI: begin
        running_crc_next = crc8_byte(CRC_INIT, frame.data_byte);
        high_byte_next   = frame.data_byte;
        position_next    = pos_eff + 3'd1;
      end
      POS_T_LO: begin
        running_crc_next = crc8_byte(running_crc, frame.data_byte);
        position_next    = POS_T_CRC;
        has_op           = 1'b1;
        push_op.kind     = OP_TRAW;
      end
      POS_T_CRC: begin
        running_crc_next = CRC_INIT;
        position_next    = POS_H_HI;
        has_op           = 1'b1;
        push_op.kind     = OP_TCHK;
      end
      POS_H_LO: begin
        running_crc_next = crc8_byte(running_crc, frame.data_byte);
        position_next    = POS_H_CRC;
        has_op           = 1'b1;
        push_op.kind     = OP_HRAW;
      end
      default: begin
        running_crc_next = CRC_INIT;
        position_next    = POS_T_HI;
        has_op           = 1'b1;
        push_op.kind     = OP_HCHK;
      end
    endcase
  end

  // Every byte waits for queue room so ops stay in order
  assign frame.ready = push_ready;
  assign accept      = frame.valid && push_ready;
  assign push_valid  = frame.valid && has_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= POS_T_HI;
      running_crc <= CRC_INIT;
      high_byte   <= 8'd0;
    end else if (accept) begin
      position    <= position_next;
      running_crc <= running_crc_next;
      high_byte   <= high_byte_next;
    end
  end

  `HSFD_ASSERT_IMPL(a_pos_range, 1'b1, position <= POS_H_CRC)

endmodule

### src/hsfd_queue.sv
`include "humidity_sensor_frame_decoder_macros.svh"

module hsfd_queue
  import hsfd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  hsfd_op_t push_op,
  output logic     pop_valid,
  input  logic     pop_ready,
  output hsfd_op_t pop_op
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hsfd_op_t       mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  `HSFD_ASSERT_IMPL(a_count_max, 1'b1, count <= CW'(DEPTH))

endmodule

### src/hsfd_back.sv
`include "humidity_sensor_frame_decoder_macros.svh"

module hsfd_back
  import hsfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  hsfd_op_t  pop_op,
  hsfd_out_if.source reading
);

  logic        advance;
  logic [14:0] mult_k;
  logic [30:0] product;

  // Stage 1: conversion product
  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic        s1_ok;
  logic [30:0] s1_prod;

  // Stage 2: held readings
  logic [14:0] pending_temp;
  logic [6:0]  pending_hum;
  logic        temp_ok;
  logic [14:0] held_temp;
  logic [6:0]  held_hum;
  logic [15:0] temp_conv;
  logic [6:0]  held_hum_next;

  // Whole back end moves when the output register is free
  assign advance   = !reading.valid || reading.ready;
  assign pop_ready = advance;

  assign mult_k  = (pop_op.kind == OP_TRAW) ? TEMP_SCALE : HUM_SCALE;
  assign product = {15'd0, pop_op.raw} * {16'd0, mult_k};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_kind <= pop_op.kind;
      s1_ok   <= pop_op.ok;
      s1_prod <= product;
    end
  end

  // Scaled temperature minus offset, fits 15 bits signed
  assign temp_conv     = {1'b0, s1_prod[30:16]} - TEMP_OFFSET;
  assign held_hum_next = s1_ok ? pending_hum : held_hum;

  // Stage 2 state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_temp  <= '0;
      pending_hum   <= '0;
      temp_ok       <= 1'b0;
      held_temp     <= '0;
      held_hum      <= '0;
      reading.valid <= 1'b0;
    end else if (advance) begin
      reading.valid <= 1'b0;
      if (s1_valid) begin
        unique case (s1_kind)
          OP_TRAW: begin
            pending_temp <= temp_conv[14:0];
          end
          OP_TCHK: begin
            temp_ok <= s1_ok;
            if (s1_ok) begin
              held_temp <= pending_temp;
            end
          end
          OP_HRAW: begin
            pending_hum <= s1_prod[22:16];
          end
          default: begin
            held_hum                  <= held_hum_next;
            reading.valid             <= 1'b1;
            reading.temperature_centi <= held_temp;
            reading.humidity_percent  <= held_hum_next;
            reading.temperature_fresh <= temp_ok;
            reading.humidity_fresh    <= s1_ok;
          end
        endcase
      end
    end
  end

  `HSFD_ASSERT_NEXT(a_word_from_hchk, advance && !(s1_valid && s1_kind == OP_HCHK),
                    !reading.valid)
  `HSFD_ASSERT_IMPL(a_temp_range, reading.valid,
                    reading.temperature_centi >= -15'sd4500 || !reading.temperature_fresh)
  `HSFD_ASSERT_IMPL(a_hum_range, 1'b1, held_hum <= 7'd100)

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import hsfd_pkg::*;

  // Frame positions of the readout, in arrival order
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  localparam int FRAME_LEN   = 6;
  localparam int TOTAL_BYTES = 975;   // directed bytes plus about 950 random
  localparam int LONG_HOLD   = 400;   // reading side held off, fills the op queue
  localparam int DRAIN_WAIT  = 20;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } frame_byte_t;

  typedef struct packed {
    logic signed [14:0] temp;
    logic [6:0]         hum;
    logic               t_fresh;
    logic               h_fresh;
  } reading_t;

  logic clk;
  logic rst;

  hsfd_in_if  frame_ch ();
  hsfd_out_if reading_ch ();

  humidity_sensor_frame_decoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame_ch),
    .reading (reading_ch)
  );

  frame_byte_t frame_bytes[$];
  reading_t    expected_readings[$];
  int          mismatch_count = 0;

  // Decoder shadow state
  logic [2:0]  dec_pos    = POS_T_HI;
  logic [7:0]  dec_crc    = CRC_INIT;
  logic [7:0]  dec_hi     = 8'd0;
  logic        dec_t_ok   = 1'b0;
  logic [14:0] dec_held_t = 15'd0;
  logic [6:0]  dec_held_h = 7'd0;
  logic [14:0] dec_pend_t = 15'd0;

  // Driver / monitor state
  frame_byte_t nxt_byte;
  int          send_gap;
  int          send_calm;
  int          recv_stall;
  int          recv_calm;
  int          readings_seen;
  int          long_holds;
  reading_t    want;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  // CRC-8, poly 0x31, MSB first, one byte
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 999);
    if (r < 450) return 0;
    if (r < 800) return $urandom_range(1, 3);
    if (r < 960) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (mismatch_count < MAX_PRINTS) begin
      $display("ERROR @%0t: %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    end
    mismatch_count++;
  endtask

  // Queue one readout frame; keep < FRAME_LEN cuts it short
  task automatic push_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                            input bit t_good, input bit h_good, input bit mark,
                            input int keep);
    logic [7:0] seq [FRAME_LEN];
    seq[0] = t_raw[15:8];
    seq[1] = t_raw[7:0];
    seq[2] = crc8_next(crc8_next(CRC_INIT, t_raw[15:8]), t_raw[7:0]);
    seq[3] = h_raw[15:8];
    seq[4] = h_raw[7:0];
    seq[5] = crc8_next(crc8_next(CRC_INIT, h_raw[15:8]), h_raw[7:0]);
    if (!t_good) seq[2] = seq[2] ^ 8'($urandom_range(1, 255));
    if (!h_good) seq[5] = seq[5] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < keep; i++) begin
      frame_bytes.push_back({seq[i], (i == 0) && mark});
    end
  endtask

  // Advance the decoder by one accepted byte; a finished frame queues a reading
  function automatic void decode_byte(input logic [7:0] b, input logic start);
    logic [2:0]         pos;
    logic [31:0]        prod;
    logic signed [16:0] centi;
    reading_t           r;
    pos = dec_pos;
    if (start || pos > POS_H_CRC) begin
      pos = POS_T_HI;
      dec_crc = CRC_INIT;
    end
    case (pos)
      POS_T_HI, POS_H_HI: begin
        dec_crc = crc8_next(CRC_INIT, b);
        dec_hi = b;
        dec_pos = pos + 3'd1;
      end
      POS_T_LO: begin
        dec_crc = crc8_next(dec_crc, b);
        prod = 32'({dec_hi, b}) * 32'(TEMP_SCALE);
        centi = $signed({1'b0, prod[31:16]}) - $signed({1'b0, TEMP_OFFSET});
        dec_pend_t = centi[14:0];
        dec_pos = POS_T_CRC;
      end
      POS_T_CRC: begin
        dec_t_ok = (dec_crc == b);
        if (dec_t_ok) dec_held_t = dec_pend_t;
        dec_crc = CRC_INIT;
        dec_pos = POS_H_HI;
      end
      POS_H_LO: begin
        dec_crc = crc8_next(dec_crc, b);
        prod = 32'({dec_hi, b}) * 32'(HUM_SCALE);
        dec_hi = prod[23:16];   // converted humidity waits here for its CRC
        dec_pos = POS_H_CRC;
      end
      default: begin
        r.h_fresh = (dec_crc == b);
        if (r.h_fresh) dec_held_h = dec_hi[6:0];
        dec_crc = CRC_INIT;
        dec_pos = POS_T_HI;
        r.temp = dec_held_t;
        r.hum = dec_held_h;
        r.t_fresh = dec_t_ok;
        expected_readings.push_back(r);
      end
    endcase
  endfunction

  // Byte driver
  always @(posedge clk) begin
    if (rst) begin
      frame_ch.valid <= 1'b0;
      send_gap <= 0;
      send_calm <= 0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        decode_byte(frame_ch.data_byte, frame_ch.frame_start);
      end
      if (!frame_ch.valid || frame_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          frame_ch.valid <= 1'b0;
        end else if (frame_bytes.size() > 0) begin
          nxt_byte = frame_bytes.pop_front();
          frame_ch.valid <= 1'b1;
          frame_ch.data_byte <= nxt_byte.data;
          frame_ch.frame_start <= nxt_byte.start;
          if (send_calm > 0) begin
            send_calm <= send_calm - 1;
            send_gap <= 0;
          end else begin
            send_gap <= pick_gap();
            if ($urandom_range(0, 79) == 0) send_calm <= $urandom_range(40, 120);
          end
        end else begin
          frame_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Reading monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      reading_ch.ready <= 1'b0;
      recv_stall <= 0;
      recv_calm <= 0;
      readings_seen <= 0;
      long_holds <= 0;
    end else begin
      if (reading_ch.valid && reading_ch.ready) begin
        readings_seen <= readings_seen + 1;
        if (expected_readings.size() == 0) begin
          report_mismatch("reading with none expected", reading_ch.temperature_centi, 0);
        end else begin
          want = expected_readings.pop_front();
          if (reading_ch.temperature_centi !== want.temp)
            report_mismatch("temperature_centi", reading_ch.temperature_centi, want.temp);
          if (reading_ch.humidity_percent !== want.hum)
            report_mismatch("humidity_percent", reading_ch.humidity_percent, want.hum);
          if (reading_ch.temperature_fresh !== want.t_fresh)
            report_mismatch("temperature_fresh", reading_ch.temperature_fresh, want.t_fresh);
          if (reading_ch.humidity_fresh !== want.h_fresh)
            report_mismatch("humidity_fresh", reading_ch.humidity_fresh, want.h_fresh);
        end
      end
      // Two long hold-offs back up the decoder into its input
      if (long_holds < 2 && readings_seen >= 30 + 60 * long_holds) begin
        long_holds <= long_holds + 1;
        recv_stall <= LONG_HOLD;
        reading_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        reading_ch.ready <= 1'b0;
      end else begin
        reading_ch.ready <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm <= recv_calm - 1;
        end else begin
          recv_stall <= pick_gap();
          if ($urandom_range(0, 79) == 0) recv_calm <= $urandom_range(40, 120);
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    bit need_mark;
    int keep;
    rst = 1'b1;
    frame_ch.valid = 1'b0;
    frame_ch.data_byte = 8'd0;
    frame_ch.frame_start = 1'b0;
    reading_ch.ready = 1'b0;

    // Directed: word extremes, back-to-back frame without mark, CRC fails,
    // frame restarts in the middle of a frame
    push_frame(16'h0000, 16'hFFFF, 1, 1, 1, FRAME_LEN);
    push_frame(16'hFFFF, 16'h0000, 1, 0, 0, FRAME_LEN);
    push_frame(16'h1234, 16'h5678, 1, 1, 1, 3);
    push_frame(16'hABCD, 16'h0F0F, 1, 1, 1, 2);
    push_frame(16'h8000, 16'hFFFF, 0, 1, 1, FRAME_LEN);

    // Random: mostly whole frames, some cut short, some CRCs broken
    need_mark = 1'b0;
    while (frame_bytes.size() < TOTAL_BYTES) begin
      keep = ($urandom_range(0, 99) < 12) ? $urandom_range(1, 5) : FRAME_LEN;
      push_frame(pick_word(), pick_word(), $urandom_range(0, 4) != 0,
                 $urandom_range(0, 4) != 0,
                 need_mark ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 1) == 1),
                 keep);
      need_mark = (keep < FRAME_LEN);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (frame_bytes.size() != 0 || frame_ch.valid);
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
